### rtl/lpg_pkg.sv
// Shared types, constants and the sine table function of the LED pixel pattern generator.
`default_nettype none

package lpg_pkg;

   // Limits and reset values of the configuration registers.
   localparam int MAX_PIXELS   = 256;
   localparam int MAX_BARS     = 64;
   localparam int SINE_ENTRIES = 1024;

   localparam logic [8:0] PPB_RESET  = 9'd8;
   localparam logic [6:0] BARS_RESET = 7'd4;
   localparam logic [8:0] TAIL_FULL  = 9'd256;
   localparam logic [8:0] FULL_BRIGHT = 9'd256;

   localparam logic [31:0] HASH_MUL     = 32'h9E37_79B1;
   localparam logic [11:0] HASH_BAR_MUL = 12'd31;

   localparam int QUEUE_DEPTH = 4;

   // Register indexes of the configuration port.
   localparam logic CSR_PIXELS_PER_BAR = 1'b0;
   localparam logic CSR_BAR_COUNT      = 1'b1;

   // Sine polynomial constants (Q30).
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] POLY_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef enum logic [3:0] {
      OP_CHASE_UP   = 4'd0,
      OP_CHASE_DOWN = 4'd1,
      OP_PING_PONG  = 4'd2,
      OP_SNAKE      = 4'd3,
      OP_SINE_WAVE  = 4'd4,
      OP_SPARKLE    = 4'd5,
      OP_BREATHE    = 4'd6,
      OP_SWEEP_UP   = 4'd7,
      OP_SWEEP_DOWN = 4'd8,
      OP_STROBE     = 4'd9,
      OP_KICK       = 4'd10,
      OP_ALT_BARS   = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      SEL_DIRECT,
      SEL_WAVE,
      SEL_SPARK
   } out_sel_type;

   // One classified transaction as it leaves the front end.
   typedef struct packed {
      op_type      op;
      logic [31:0] t;
      logic [5:0]  bar;
      logic [8:0]  pix;
      logic        tail_zero;
      logic [8:0]  np;
      logic [15:0] total;
      logic [8:0]  s0;
      logic [15:0] gid;
      logic [16:0] dcomet;
      logic [31:0] hash;
      logic [6:0]  nb;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [17:0] v;
   } wrap_ctx_type;

   typedef struct packed {
      item_type   item;
      logic       fix;
      logic [8:0] fix_br;
   } ctx_type;

   // Table entry for one sine step: {sparkle bit, wave brightness}.
   function automatic logic [9:0] sine_entry(input logic [31:0] f);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] s;
      logic [63:0] q;
      logic [63:0] w;
      logic        spark;
      r = {34'd0, f[29:0]};
      if (f[30]) begin
         r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      s  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
         s = Q30_ONE - (((x2 * s) >> 30) / POLY_DIV[i]);
      end
      s = (x * s) >> 30;
      q = (s + 64'd8192) >> 14;
      if (f[31]) begin
         w     = (64'd65536 - q) >> 9;
         spark = 1'b0;
      end else begin
         w     = (64'd65536 + q) >> 9;
         spark = (q * 64'd5) > 64'd196608;
      end
      return {spark, w[8:0]};
   endfunction

endpackage

`default_nettype wire

### rtl/lpg_divpipe.sv
// Pipelined restoring divider: one quotient bit per stage, payload carried alongside.
`default_nettype none

module lpg_divpipe #(
   parameter int STEPS = 16,
   parameter int DW    = 16,
   parameter int PAY_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [STEPS-1:0] in_num,
   input  wire logic [DW-1:0]    in_rem,
   input  wire logic [DW-1:0]    in_den,
   input  wire logic [PAY_W-1:0] in_pay,
   output logic                  out_valid,
   output logic [STEPS-1:0]      out_quo,
   output logic [DW-1:0]         out_rem,
   output logic [PAY_W-1:0]      out_pay
);

   logic             valid_ff [STEPS];
   logic [DW-1:0]    rem_ff   [STEPS];
   logic [DW-1:0]    den_ff   [STEPS];
   logic [STEPS-1:0] num_ff   [STEPS];
   logic [STEPS-1:0] quo_ff   [STEPS];
   logic [PAY_W-1:0] pay_ff   [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic             valid_prev;
      logic [DW-1:0]    rem_prev;
      logic [DW-1:0]    den_prev;
      logic [STEPS-1:0] num_prev;
      logic [STEPS-1:0] quo_prev;
      logic [PAY_W-1:0] pay_prev;
      logic [DW:0]      trial;
      logic [DW:0]      diff;
      logic             take;
      logic [DW-1:0]    rem_in;

      if (g == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_rem;
         assign den_prev   = in_den;
         assign num_prev   = in_num;
         assign quo_prev   = '0;
         assign pay_prev   = in_pay;
      end else begin : g_next
         assign valid_prev = valid_ff[g-1];
         assign rem_prev   = rem_ff[g-1];
         assign den_prev   = den_ff[g-1];
         assign num_prev   = num_ff[g-1];
         assign quo_prev   = quo_ff[g-1];
         assign pay_prev   = pay_ff[g-1];
      end

      // Shift in the next dividend bit, subtract the divisor where it fits.
      assign trial  = {rem_prev, num_prev[STEPS-1]};
      assign take   = trial >= {1'b0, den_prev};
      assign diff   = trial - {1'b0, den_prev};
      assign rem_in = take ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         den_ff[g] <= den_prev;
         num_ff[g] <= num_prev << 1;
         quo_ff[g] <= (quo_prev << 1) | STEPS'(take);
         pay_ff[g] <= pay_prev;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_rem   = rem_ff[STEPS-1];
   assign out_pay   = pay_ff[STEPS-1];

endmodule

`default_nettype wire

### rtl/lpg_front.sv
// Front end: configuration registers, transaction accept and classification.
`default_nettype none

module lpg_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [3:0]        req_op,
   input  wire logic [31:0]       req_beat_time,
   input  wire logic [5:0]        req_bar_index,
   input  wire logic [8:0]        req_pixel_index,
   input  wire logic [8:0]        req_tail_amount,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_index,
   input  wire logic [8:0]        csr_write_data,
   output logic                   push,
   output lpg_pkg::item_type      item
);

   logic [8:0]  ppb_ff;
   logic [6:0]  bars_ff;
   logic [8:0]  np;
   logic [6:0]  nb;
   logic [8:0]  tail;
   logic [24:0] step_prod;
   logic [17:0] dcomet_prod;
   logic [14:0] bar_base;
   logic [11:0] hash_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppb_ff  <= lpg_pkg::PPB_RESET;
         bars_ff <= lpg_pkg::BARS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            lpg_pkg::CSR_PIXELS_PER_BAR: ppb_ff  <= csr_write_data;
            lpg_pkg::CSR_BAR_COUNT:      bars_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // Clamp registers and tail into range.
      if (ppb_ff == 9'd0) begin
         np = 9'd1;
      end else if (ppb_ff > 9'(lpg_pkg::MAX_PIXELS)) begin
         np = 9'(lpg_pkg::MAX_PIXELS);
      end else begin
         np = ppb_ff;
      end
      if (bars_ff == 7'd0) begin
         nb = 7'd1;
      end else if (bars_ff > 7'(lpg_pkg::MAX_BARS)) begin
         nb = 7'(lpg_pkg::MAX_BARS);
      end else begin
         nb = bars_ff;
      end
      tail = (req_tail_amount > lpg_pkg::TAIL_FULL) ? lpg_pkg::TAIL_FULL : req_tail_amount;

      step_prod   = 25'(req_beat_time[15:0]) * 25'(np);
      dcomet_prod = 18'(tail) * 18'(np);
      bar_base    = 15'(req_bar_index) * 15'(np);
      hash_key    = 12'(req_bar_index) * lpg_pkg::HASH_BAR_MUL + 12'(req_pixel_index);

      item.op        = lpg_pkg::op_type'(req_op);
      item.t         = req_beat_time;
      item.bar       = req_bar_index;
      item.pix       = req_pixel_index;
      item.tail_zero = (tail == 9'd0);
      item.np        = np;
      item.nb        = nb;
      item.total     = 16'(np) * 16'(nb);
      item.s0        = step_prod[24:16];
      item.gid       = 16'(bar_base) + 16'(req_pixel_index);
      item.dcomet    = dcomet_prod[16:0];
      item.hash      = 32'(32'(hash_key) * lpg_pkg::HASH_MUL);
   end

   assign push = start && !busy;

endmodule

`default_nettype wire

### rtl/lpg_fifo.sv
// Short queue between the front end and the back end.
`default_nettype none

module lpg_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lpg_pkg::item_type push_item,
   output logic                   full,
   output logic                   pop_valid,
   output lpg_pkg::item_type      pop_item
);

   localparam int DEPTH = lpg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpg_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              pop;

   // The back end never stalls: drain one entry whenever one is present.
   assign pop       = (count_ff != '0);
   assign pop_valid = pop;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### rtl/lpg_back.sv
// Back end: modulo and division pipelines, sine table and brightness selection.
`default_nettype none

module lpg_back #(
   parameter int SINE_ENTRIES = lpg_pkg::SINE_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire lpg_pkg::item_type in_item,
   output logic                   out_strobe,
   output logic [8:0]             out_brightness,
   output logic                   out_valid_res
);

   localparam int IDX_W     = $clog2(SINE_ENTRIES);
   localparam int ROM_SHIFT = 32 - IDX_W;
   localparam int ITEM_W    = $bits(lpg_pkg::item_type);
   localparam int WRAP_W    = $bits(lpg_pkg::wrap_ctx_type);
   localparam int CTX_W     = $bits(lpg_pkg::ctx_type);

   typedef logic [9:0] rom_type [SINE_ENTRIES];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         rom[k] = lpg_pkg::sine_entry(32'(k) << ROM_SHIFT);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Bar-count modulo of the whole beats.
   logic              a_valid;
   logic [6:0]        a_rem;
   logic [ITEM_W-1:0] a_pay;
   lpg_pkg::item_type a_item;

   lpg_divpipe #(.STEPS(16), .DW(7), .PAY_W(ITEM_W)) u_bar_mod (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_num   (in_item.t[31:16]),
      .in_rem   (7'd0),
      .in_den   (in_item.nb),
      .in_pay   (in_item),
      .out_valid(a_valid),
      .out_quo  (),
      .out_rem  (a_rem),
      .out_pay  (a_pay)
   );
   assign a_item = lpg_pkg::item_type'(a_pay);

   // Snake head base.
   logic              b1_valid_ff;
   lpg_pkg::item_type b1_item_ff;
   logic [15:0]       b1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= a_valid;
      end
   end
   always_ff @(posedge clock) begin
      b1_item_ff <= a_item;
      b1_prod_ff <= 16'(a_rem) * 16'(a_item.np);
   end

   // Signed distance and modulus for the wrap.
   logic [17:0]          v_in;
   logic [15:0]          m_in;
   logic                 b2_valid_ff;
   lpg_pkg::wrap_ctx_type b2_ctx_ff;
   logic [15:0]          b2_mag_ff;
   logic [15:0]          b2_mod_ff;

   always_comb begin
      m_in = 16'(b1_item_ff.np);
      case (b1_item_ff.op)
         lpg_pkg::OP_CHASE_UP: begin
            v_in = 18'(b1_item_ff.s0) + 18'd1 - 18'(b1_item_ff.pix);
         end
         lpg_pkg::OP_CHASE_DOWN: begin
            v_in = 18'(b1_item_ff.pix) - (18'(b1_item_ff.np) - 18'(b1_item_ff.s0));
         end
         lpg_pkg::OP_PING_PONG: begin
            if (!b1_item_ff.t[16]) begin
               v_in = 18'(b1_item_ff.s0) + 18'd1 - 18'(b1_item_ff.pix);
            end else begin
               v_in = 18'(b1_item_ff.pix) - (18'(b1_item_ff.np) - 18'(b1_item_ff.s0));
            end
         end
         lpg_pkg::OP_SNAKE: begin
            v_in = 18'(b1_prod_ff) + 18'(b1_item_ff.s0) + 18'd1 - 18'(b1_item_ff.gid);
            m_in = b1_item_ff.total;
         end
         lpg_pkg::OP_SINE_WAVE: begin
            v_in = 18'(b1_item_ff.pix) - 18'd1;
         end
         default: begin
            v_in = 18'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      b2_ctx_ff.item <= b1_item_ff;
      b2_ctx_ff.v    <= v_in;
      b2_mag_ff      <= v_in[17] ? 16'(-v_in) : 16'(v_in);
      b2_mod_ff      <= m_in;
   end

   // Wrap modulo over the track.
   logic              c_valid;
   logic [15:0]       c_rem;
   logic [WRAP_W-1:0] c_pay;
   lpg_pkg::wrap_ctx_type c_ctx;

   lpg_divpipe #(.STEPS(16), .DW(16), .PAY_W(WRAP_W)) u_wrap_mod (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b2_valid_ff),
      .in_num   (b2_mag_ff),
      .in_rem   (16'd0),
      .in_den   (b2_mod_ff),
      .in_pay   (b2_ctx_ff),
      .out_valid(c_valid),
      .out_quo  (),
      .out_rem  (c_rem),
      .out_pay  (c_pay)
   );
   assign c_ctx = lpg_pkg::wrap_ctx_type'(c_pay);

   // Comet classification and divider setup.
   logic [15:0]     m_c;
   logic [15:0]     w_c;
   logic [17:0]     behind;
   logic [23:0]     behind_sh;
   logic            sat;
   lpg_pkg::ctx_type d_ctx_in;
   logic [16:0]     rem0_in;
   logic [16:0]     den_in;
   logic            d_valid_ff;
   lpg_pkg::ctx_type d_ctx_ff;
   logic [16:0]     d_rem0_ff;
   logic [16:0]     d_den_ff;

   always_comb begin
      m_c = (c_ctx.item.op == lpg_pkg::OP_SNAKE) ? c_ctx.item.total : 16'(c_ctx.item.np);
      w_c = (c_ctx.v[17] && c_rem != 16'd0) ? m_c - c_rem : c_rem;
      behind    = (c_ctx.item.op == lpg_pkg::OP_PING_PONG) ? c_ctx.v : 18'(w_c);
      behind_sh = {behind[15:0], 8'd0};
      sat       = behind_sh >= 24'(c_ctx.item.dcomet);

      d_ctx_in.item   = c_ctx.item;
      d_ctx_in.fix    = 1'b1;
      d_ctx_in.fix_br = 9'd0;
      rem0_in = 17'd0;
      den_in  = 17'd1;

      if (c_ctx.item.op inside {lpg_pkg::OP_CHASE_UP, lpg_pkg::OP_CHASE_DOWN,
                                lpg_pkg::OP_PING_PONG, lpg_pkg::OP_SNAKE}) begin
         if (behind[17]) begin
            d_ctx_in.fix_br = 9'd0;
         end else if (c_ctx.item.tail_zero) begin
            d_ctx_in.fix_br = (behind == 18'd0) ? lpg_pkg::FULL_BRIGHT : 9'd0;
         end else if (sat) begin
            d_ctx_in.fix_br = 9'd0;
         end else begin
            d_ctx_in.fix = 1'b0;
            rem0_in      = behind_sh[16:0];
            den_in       = c_ctx.item.dcomet;
         end
      end else if (c_ctx.item.op == lpg_pkg::OP_SINE_WAVE) begin
         rem0_in = 17'(w_c);
         den_in  = 17'(c_ctx.item.np);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid;
      end
   end
   always_ff @(posedge clock) begin
      d_ctx_ff  <= d_ctx_in;
      d_rem0_ff <= rem0_in;
      d_den_ff  <= den_in;
   end

   // Fraction divider: comet fade and pixel phase.
   logic             e_valid;
   logic [31:0]      e_quo;
   logic [CTX_W-1:0] e_pay;
   lpg_pkg::ctx_type e_ctx;

   lpg_divpipe #(.STEPS(32), .DW(17), .PAY_W(CTX_W)) u_frac_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (d_valid_ff),
      .in_num   (32'd0),
      .in_rem   (d_rem0_ff),
      .in_den   (d_den_ff),
      .in_pay   (d_ctx_ff),
      .out_valid(e_valid),
      .out_quo  (e_quo),
      .out_rem  (),
      .out_pay  (e_pay)
   );
   assign e_ctx = lpg_pkg::ctx_type'(e_pay);

   // Brightness of the direct recipes and the sine table address.
   logic [31:0]          turn;
   logic [8:0]           br_in;
   logic                 ok_in;
   lpg_pkg::out_sel_type sel_in;
   logic [9:0]           fill;
   logic [16:0]          kick_lvl;
   logic                 f_valid_ff;
   logic [IDX_W-1:0]     f_idx_ff;
   logic [8:0]           f_br_ff;
   logic                 f_ok_ff;
   lpg_pkg::out_sel_type f_sel_ff;

   always_comb begin
      case (e_ctx.item.op)
         lpg_pkg::OP_SINE_WAVE: turn = {e_ctx.item.t[15:0], 16'd0} - e_quo;
         lpg_pkg::OP_SPARKLE:   turn = e_ctx.item.hash + {e_ctx.item.t[13:0], 18'd0};
         default:               turn = {e_ctx.item.t[17:0], 14'd0};
      endcase

      kick_lvl = 17'd65536 - {1'b0, e_ctx.item.t[13:0], 2'b00};
      fill     = 10'd0;
      br_in    = 9'd0;
      ok_in    = 1'b1;
      sel_in   = lpg_pkg::SEL_DIRECT;
      case (e_ctx.item.op)
         lpg_pkg::OP_CHASE_UP, lpg_pkg::OP_CHASE_DOWN,
         lpg_pkg::OP_PING_PONG, lpg_pkg::OP_SNAKE: begin
            br_in = e_ctx.fix ? e_ctx.fix_br : lpg_pkg::FULL_BRIGHT - 9'(e_quo[31:24]);
         end
         lpg_pkg::OP_SINE_WAVE, lpg_pkg::OP_BREATHE: begin
            sel_in = lpg_pkg::SEL_WAVE;
         end
         lpg_pkg::OP_SPARKLE: begin
            sel_in = lpg_pkg::SEL_SPARK;
         end
         lpg_pkg::OP_SWEEP_UP: begin
            fill  = 10'(e_ctx.item.s0) + 10'd1;
            br_in = (10'(e_ctx.item.pix) <= fill) ? lpg_pkg::FULL_BRIGHT : 9'd0;
         end
         lpg_pkg::OP_SWEEP_DOWN: begin
            fill  = 10'(e_ctx.item.np) - 10'(e_ctx.item.s0);
            br_in = (10'(e_ctx.item.pix) >= fill) ? lpg_pkg::FULL_BRIGHT : 9'd0;
         end
         lpg_pkg::OP_KICK: begin
            br_in = (e_ctx.item.t[15:14] == 2'b00) ? kick_lvl[16:8] : 9'd0;
         end
         lpg_pkg::OP_ALT_BARS: begin
            br_in = (e_ctx.item.t[16] == e_ctx.item.bar[0]) ? lpg_pkg::FULL_BRIGHT : 9'd0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid;
      end
   end
   always_ff @(posedge clock) begin
      f_idx_ff <= turn[31 -: IDX_W];
      f_br_ff  <= br_in;
      f_ok_ff  <= ok_in;
      f_sel_ff <= sel_in;
   end

   // Sine table read.
   logic                 g_valid_ff;
   logic [9:0]           g_rom_ff;
   logic [8:0]           g_br_ff;
   logic                 g_ok_ff;
   lpg_pkg::out_sel_type g_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      g_rom_ff <= SINE_ROM[f_idx_ff];
      g_br_ff  <= f_br_ff;
      g_ok_ff  <= f_ok_ff;
      g_sel_ff <= f_sel_ff;
   end

   // Result register.
   logic       out_strobe_ff;
   logic [8:0] out_br_ff;
   logic       out_ok_ff;
   logic [8:0] out_br_in;

   always_comb begin
      case (g_sel_ff)
         lpg_pkg::SEL_WAVE:  out_br_in = g_rom_ff[8:0];
         lpg_pkg::SEL_SPARK: out_br_in = g_rom_ff[9] ? lpg_pkg::FULL_BRIGHT : 9'd0;
         default:            out_br_in = g_br_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= g_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      out_br_ff <= out_br_in;
      out_ok_ff <= g_ok_ff;
   end

   assign out_strobe     = out_strobe_ff;
   assign out_brightness = out_br_ff;
   assign out_valid_res  = out_ok_ff;

endmodule

`default_nettype wire

### rtl/led_pixel_pattern_generator.sv
// Top level of the LED pixel pattern generator: front end, queue and back end.
// Throughput: one transaction per cycle, set by the fully pipelined dividers of the back end.
// The back end never stalls, so busy stays low in operation; results cannot be held off.
// Reset (synchronous, active high) restores pixels_per_bar to 8 and bar_count to 4
// and empties every pipeline stage and the queue.
`default_nettype none

module led_pixel_pattern_generator #(
   parameter int SINE_ENTRIES = lpg_pkg::SINE_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel: accepted when start is high and busy is low.
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_op,
   input  wire logic [31:0] req_beat_time,
   input  wire logic [5:0]  req_bar_index,
   input  wire logic [8:0]  req_pixel_index,
   input  wire logic [8:0]  req_tail_amount,
   // Result channel: each result is marked by rsp_strobe.
   output logic             rsp_strobe,
   output logic [8:0]       rsp_brightness,
   output logic             rsp_valid_res,
   // Configuration write port.
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_write_data
);

   logic              push;
   logic              queue_full;
   logic              pop_valid;
   lpg_pkg::item_type push_item;
   lpg_pkg::item_type pop_item;

   // Front end: hold the configuration, clamp it, and classify each transaction.
   // The products it forms (phase step, tail span, bar base, hash) go to the queue.
   lpg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (queue_full),
      .req_op          (req_op),
      .req_beat_time   (req_beat_time),
      .req_bar_index   (req_bar_index),
      .req_pixel_index (req_pixel_index),
      .req_tail_amount (req_tail_amount),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .push            (push),
      .item            (push_item)
   );

   // Queue: decouple accept from the back end; drain one entry per cycle.
   lpg_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (queue_full),
      .pop_valid(pop_valid),
      .pop_item (pop_item)
   );

   // Back end: bar modulo, track wrap, fade or phase division, sine table, result register.
   lpg_back #(.SINE_ENTRIES(SINE_ENTRIES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pop_valid),
      .in_item       (pop_item),
      .out_strobe    (rsp_strobe),
      .out_brightness(rsp_brightness),
      .out_valid_res (rsp_valid_res)
   );

   // Raise busy only when the queue cannot take another transaction.
   assign busy = queue_full;

endmodule

`default_nettype wire

### tb/tb_led_pixel_pattern_generator.sv
// Self-checking testbench of the LED pixel pattern generator.
`timescale 1ns / 1ps

module tb_led_pixel_pattern_generator;

   // Codes 12..15 name no recipe; the block must flag them as not computed.
   localparam logic [3:0] OP_UNUSED_FIRST = 4'd12;
   localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [8:0] brightness;
      logic       valid_res;
   } pixel_result_type;

   // Holds the pixel predictor, its copy of the registers and the expected results.
   class pixel_scoreboard_type;
      pixel_result_type pending_pixels[$];
      logic [8:0]  ppb_reg;
      logic [6:0]  bars_reg;
      int          errors;

      function new();
         ppb_reg  = lpg_pkg::PPB_RESET;
         bars_reg = lpg_pkg::BARS_RESET;
         errors   = 0;
      endfunction

      function void write_reg(logic idx, logic [8:0] value);
         if (idx == lpg_pkg::CSR_PIXELS_PER_BAR) begin
            ppb_reg = value;
         end else begin
            bars_reg = value[6:0];
         end
      endfunction

      function longint wrap_mod(longint a, longint m);
         longint r;
         r = a % m;
         return (r < 0) ? r + m : r;
      endfunction

      // Q16 sine of a turn fraction, quantized to the table step.
      function longint sine_q16(logic [31:0] turn);
         logic [63:0] k;
         logic [31:0] f;
         logic [63:0] r, x, x2, s;
         longint      q;
         k = ({32'd0, turn} * 64'(lpg_pkg::SINE_ENTRIES)) >> 32;
         f = 32'((k << 32) / 64'(lpg_pkg::SINE_ENTRIES));
         r = {34'd0, f[29:0]};
         if (f[30]) begin
            r = lpg_pkg::Q30_ONE - r;
         end
         x  = (r * lpg_pkg::HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         s  = lpg_pkg::Q30_ONE;
         for (int i = 0; i < 5; i++) begin
            s = lpg_pkg::Q30_ONE - (((x2 * s) >> 30) / lpg_pkg::POLY_DIV[i]);
         end
         s = (x * s) >> 30;
         q = longint'((s + 64'd8192) >> 14);
         return f[31] ? -q : q;
      endfunction

      function longint wave(logic [31:0] turn);
         return (65536 + sine_q16(turn)) >>> 9;
      endfunction

      // Comet head with a linear tail; nothing ahead of the head.
      function longint comet(longint behind, longint npix, longint tail);
         longint q;
         if (behind < 0) return 0;
         if (tail == 0) return (behind == 0) ? 256 : 0;
         q = (behind * 65536) / (tail * npix);
         return (q < 256) ? 256 - q : 0;
      endfunction

      function pixel_result_type predict_pixel(logic [3:0] op, logic [31:0] t,
                                               logic [5:0] bar, logic [8:0] pix,
                                               logic [8:0] tail_in);
         pixel_result_type res;
         longint np, nb, tail, steps, pos, ph, fill, total, gid, p, b, tl;
         logic [31:0] turn;
         np = ppb_reg;
         nb = bars_reg;
         p  = pix;
         b  = bar;
         tail = tail_in;
         tl = t;
         if (np < 1) np = 1;
         if (np > lpg_pkg::MAX_PIXELS) np = lpg_pkg::MAX_PIXELS;
         if (nb < 1) nb = 1;
         if (nb > lpg_pkg::MAX_BARS) nb = lpg_pkg::MAX_BARS;
         if (tail > 256) tail = 256;
         steps = (tl * np) >>> 16;
         res.valid_res = 1'b1;
         res.brightness = '0;
         case (op)
            lpg_pkg::OP_CHASE_UP: begin
               pos = steps % np + 1;
               res.brightness = 9'(comet(wrap_mod(pos - p, np), np, tail));
            end
            lpg_pkg::OP_CHASE_DOWN: begin
               pos = np - steps % np;
               res.brightness = 9'(comet(wrap_mod(p - pos, np), np, tail));
            end
            lpg_pkg::OP_PING_PONG: begin
               ph = tl & 64'h1FFFF;
               if (ph < 65536) begin
                  pos = ((ph * np) >>> 16) + 1;
                  res.brightness = 9'(comet(pos - p, np, tail));
               end else begin
                  pos = np - (((ph - 65536) * np) >>> 16);
                  res.brightness = 9'(comet(p - pos, np, tail));
               end
            end
            lpg_pkg::OP_SNAKE: begin
               total = nb * np;
               pos = steps % total;
               gid = b * np + p - 1;
               res.brightness = 9'(comet(wrap_mod(pos - gid, total), np, tail));
            end
            lpg_pkg::OP_SINE_WAVE: begin
               turn = 32'(tl << 16) - 32'((wrap_mod(p - 1, np) << 32) / np);
               res.brightness = 9'(wave(turn));
            end
            lpg_pkg::OP_SPARKLE: begin
               turn = 32'(32'(32'(bar) * 32'd31 + 32'(pix)) * lpg_pkg::HASH_MUL);
               turn = 32'(tl << 18) + turn;
               res.brightness = (5 * sine_q16(turn) > 3 * 65536) ?
                                lpg_pkg::FULL_BRIGHT : 9'd0;
            end
            lpg_pkg::OP_BREATHE: res.brightness = 9'(wave(32'(tl << 14)));
            lpg_pkg::OP_SWEEP_UP: begin
               fill = (((tl & 64'hFFFF) * np) >>> 16) + 1;
               res.brightness = (p <= fill) ? lpg_pkg::FULL_BRIGHT : 9'd0;
            end
            lpg_pkg::OP_SWEEP_DOWN: begin
               fill = np - (((tl & 64'hFFFF) * np) >>> 16);
               res.brightness = (p >= fill) ? lpg_pkg::FULL_BRIGHT : 9'd0;
            end
            lpg_pkg::OP_KICK: begin
               ph = tl & 64'hFFFF;
               res.brightness = (ph < 16384) ? 9'((65536 - 4 * ph) >>> 8) : 9'd0;
            end
            lpg_pkg::OP_ALT_BARS: begin
               res.brightness = (t[16] == bar[0]) ? lpg_pkg::FULL_BRIGHT : 9'd0;
            end
            default: res.valid_res = 1'b0;
         endcase
         return res;
      endfunction

      function void note_request(logic [3:0] op, logic [31:0] t, logic [5:0] bar,
                                 logic [8:0] pix, logic [8:0] tail);
         pending_pixels.push_back(predict_pixel(op, t, bar, pix, tail));
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [8:0] brightness, logic valid_res);
         pixel_result_type exp_res;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected result brightness=%0d", brightness));
         end else begin
            exp_res = pending_pixels.pop_front();
            if (brightness !== exp_res.brightness)
               report($sformatf("brightness %0d, want %0d", brightness, exp_res.brightness));
            if (valid_res !== exp_res.valid_res)
               report($sformatf("valid_res %0b, want %0b", valid_res, exp_res.valid_res));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_op = '0;
   logic [31:0] req_beat_time = '0;
   logic [5:0]  req_bar_index = '0;
   logic [8:0]  req_pixel_index = '0;
   logic [8:0]  req_tail_amount = '0;
   logic        rsp_strobe;
   logic [8:0]  rsp_brightness;
   logic        rsp_valid_res;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_write_data = '0;

   pixel_scoreboard_type pixels = new();
   bit                   idling_on;

   led_pixel_pattern_generator dut (
      .clock, .reset, .start, .busy,
      .req_op, .req_beat_time, .req_bar_index, .req_pixel_index, .req_tail_amount,
      .rsp_strobe, .rsp_brightness, .rsp_valid_res,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check every strobed result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         pixels.check_result(rsp_brightness, rsp_valid_res);
      end
   end

   // Present one transaction and hold it until the block takes it.
   task send_pixel(logic [3:0] op, logic [31:0] t, logic [5:0] bar,
                   logic [8:0] pix, logic [8:0] tail);
      start           <= 1'b1;
      req_op          <= op;
      req_beat_time   <= t;
      req_bar_index   <= bar;
      req_pixel_index <= pix;
      req_tail_amount <= tail;
      do @(posedge clock); while (busy);
      pixels.note_request(op, t, bar, pix, tail);
   endtask

   // Drop start for a random burst now and then.
   task maybe_idle();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop sending until every outstanding pixel has come back.
   task drain();
      start <= 1'b0;
      while (pixels.pending_pixels.size() != 0) @(posedge clock);
   endtask

   task write_csr(logic idx, logic [8:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pixels.write_reg(idx, value);
   endtask

   task set_rig(logic [8:0] ppb, logic [6:0] bars);
      drain();
      write_csr(lpg_pkg::CSR_PIXELS_PER_BAR, ppb);
      write_csr(lpg_pkg::CSR_BAR_COUNT, {2'b00, bars});
   endtask

   // Random traffic: mostly pixels on the rig, some beyond it and some odd codes.
   task random_pixels(int count);
      logic [3:0] op;
      logic [8:0] pix, tail;
      int         span;
      for (int n = 0; n < count; n++) begin
         span = (pixels.ppb_reg == 0) ? 1 :
                (pixels.ppb_reg > lpg_pkg::MAX_PIXELS) ? lpg_pkg::MAX_PIXELS
                                                       : pixels.ppb_reg;
         op   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 11));
         pix  = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, span));
         tail = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
         send_pixel(op, $urandom, 6'($urandom), pix, tail);
         maybe_idle();
      end
   endtask

   initial begin
      idling_on = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every code at the reset rig, then the field extremes.
      for (int c = 0; c <= OP_UNUSED_LAST; c++) begin
         send_pixel(4'(c), 32'h0001_8000, 6'd1, 9'd3, 9'd128);
      end
      send_pixel(lpg_pkg::OP_CHASE_UP, 32'hFFFF_FFFF, 6'd63, 9'd256, 9'd0);
      send_pixel(lpg_pkg::OP_CHASE_DOWN, 32'h0000_0000, 6'd0, 9'd1, 9'd256);
      send_pixel(lpg_pkg::OP_PING_PONG, 32'h0001_FFFF, 6'd0, 9'd511, 9'd511);
      send_pixel(lpg_pkg::OP_PING_PONG, 32'h0000_FFFF, 6'd0, 9'd0, 9'd300);
      send_pixel(lpg_pkg::OP_SNAKE, 32'hFFFF_FFFF, 6'd63, 9'd511, 9'd256);
      send_pixel(lpg_pkg::OP_SINE_WAVE, 32'h0000_4000, 6'd0, 9'd0, 9'd0);
      send_pixel(lpg_pkg::OP_KICK, 32'h0000_3FFF, 6'd0, 9'd1, 9'd0);
      send_pixel(lpg_pkg::OP_KICK, 32'h0000_4000, 6'd0, 9'd1, 9'd0);
      send_pixel(OP_UNUSED_FIRST, 32'hFFFF_FFFF, 6'd63, 9'd511, 9'd511);
      random_pixels(250);

      // Walk the rig settings, extremes and out-of-range values included.
      set_rig(9'd1, 7'd1);
      random_pixels(200);
      set_rig(9'd256, 7'd64);
      random_pixels(200);
      set_rig(9'd0, 7'd0);
      random_pixels(150);
      set_rig(9'd511, 7'd127);
      random_pixels(200);
      set_rig(9'd3, 7'd5);
      random_pixels(200);
      set_rig(9'($urandom_range(1, 256)), 7'($urandom_range(1, 64)));
      idling_on = 1'b0;
      random_pixels(230);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixels.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
